@@ src/apt_pkg.sv @@
// allocation profile table: shared sizes, entry layout, codes and state type
// used by the interfaces and the top level
package apt_pkg;

  localparam int HOME_SLOTS     = 1024;
  localparam int OVERFLOW_SLOTS = 128;
  localparam int TABLE_SIZE     = HOME_SLOTS + OVERFLOW_SLOTS + 1;
  localparam int CATCH_ALL      = HOME_SLOTS + OVERFLOW_SLOTS;

  localparam int HOME_W = $clog2(HOME_SLOTS);
  localparam int IDX_W  = $clog2(TABLE_SIZE + 1);
  localparam int OVF_W  = $clog2(OVERFLOW_SLOTS + 1);

  localparam int FUNC_W   = 2;
  localparam int TAG_W    = 32;
  localparam int NBYTES_W = 31;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SHIFT_W  = 4;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [TAG_W-1:0]     ALL_ONES          = '1;
  localparam logic [SHIFT_W-1:0]   SHIFT_RESET       = SHIFT_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULE_SHIFT = CFG_IDX_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_READ  = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_CLAIMED  = 3'd1,
    ST_CATCHALL = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] bytes;
    logic [IDX_W-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ src/apt_if.sv @@
// request and response channels of the allocation profile table
// depends on apt_pkg for field widths
interface apt_req_if import apt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [TAG_W-1:0]    tag;
  logic [NBYTES_W-1:0] nbytes;
  logic [IDX_W-1:0]    entry_index;

  modport source (output valid, func, tag, nbytes, entry_index, input ready);
  modport sink (input valid, func, tag, nbytes, entry_index, output ready);
endinterface

interface apt_rsp_if import apt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [TAG_W-1:0]        entry_tag;
  logic signed [CNT_W-1:0] live_count;
  logic signed [CNT_W-1:0] live_bytes;
  logic                    entry_used;

  modport source (output valid, status, entry_tag, live_count, live_bytes, entry_used,
                  input ready);
  modport sink (input valid, status, entry_tag, live_count, live_bytes, entry_used,
                output ready);
endinterface

@@ src/apt_ram.sv @@
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module apt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/allocation_profile_table_top.sv @@
// allocation profile table top level: sequencer around one table ram
// depends on apt_pkg, apt_req_if / apt_rsp_if and apt_ram
//
// usage:
//   req_i carries one request (func, tag, nbytes, entry_index) per valid/ready
//   handshake; rsp_o returns one response per request, except func 3, which is
//   dropped without a response. cfg_we_i writes text_base (index 0) or
//   granule_shift (index 1) from cfg_wdata_i; write only while idle.
//   the whole table (tag, count, bytes, link per entry) sits in one ram with
//   a registered read; alloc and free requests read it and write back any entry they update; reads only read it.
// sequencing:
//   read request: the entry is read on acceptance, the response registered
//   from the check step. alloc/free: a hash step reads the home slot, then one
//   ram read per chain entry visited, plus one more when a new overflow link
//   is written. one request is in flight at a time; the next is taken as soon
//   as the sequencer is back in idle, even if a response still waits.
// reset: asynchronous, active low. afterwards a clearing pass writes all
//   TABLE_SIZE (1153) entries to zero, one per cycle, with req_i.ready low.
// stall: while rsp_o is held, a finished request waits in its last step with
//   the table write deferred, so no response is lost or overwritten.
module allocation_profile_table_top import apt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  apt_req_if.sink              req_i,
  apt_rsp_if.source            rsp_o
);

  localparam logic [IDX_W-1:0] HOME_BASE = IDX_W'(HOME_SLOTS);
  localparam logic [IDX_W-1:0] CATCH_IDX = IDX_W'(CATCH_ALL);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W-1:0] SIZE_IDX  = IDX_W'(TABLE_SIZE);
  localparam logic [OVF_W-1:0] OVF_MAX   = OVF_W'(OVERFLOW_SLOTS);

  state_e                state_q, state_d;
  func_e                 func_q, func_d;
  logic [TAG_W-1:0]      tag_q, tag_d;
  logic [NBYTES_W-1:0]   nbytes_q, nbytes_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      steps_q, steps_d;
  logic [IDX_W-1:0]      clr_q, clr_d;
  logic [OVF_W-1:0]      ovf_q, ovf_d;
  logic                  force_q, force_d;
  logic                  set_tag_q, set_tag_d;
  logic [TAG_W-1:0]      new_tag_q, new_tag_d;
  logic                  claimed_q, claimed_d;
  logic                  rdzero_q, rdzero_d;
  logic [TAG_W-1:0]      text_base_q;
  logic [SHIFT_W-1:0]    shift_q;

  logic                  rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]   rsp_status_q, rsp_status_d;
  logic [TAG_W-1:0]      rsp_tag_q, rsp_tag_d;
  logic [CNT_W-1:0]      rsp_count_q, rsp_count_d;
  logic [CNT_W-1:0]      rsp_bytes_q, rsp_bytes_d;
  logic                  rsp_used_q, rsp_used_d;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  entry_t                rd, upd;
  logic [TAG_W-1:0]      hash_diff, hash_shift;
  logic [IDX_W-1:0]      home_idx, new_idx;
  logic                  accept, out_free, claim_now, hit, chain_end;
  logic                  term, term_upd, term_zero;
  status_e               upd_status;

  apt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.entry_tag  = rsp_tag_q;
  assign rsp_o.live_count = rsp_count_q;
  assign rsp_o.live_bytes = rsp_bytes_q;
  assign rsp_o.entry_used = rsp_used_q;

  // home slot from the latched tag
  assign hash_diff  = tag_q - text_base_q;
  assign hash_shift = hash_diff >> shift_q;
  assign home_idx   = {{(IDX_W - HOME_W){1'b0}}, hash_shift[HOME_W-1:0]};

  assign rd        = entry_t'(ram_rdata);
  assign hit       = (rd.tag == tag_q) || (rd.tag == ALL_ONES);
  assign chain_end = (rd.link == '0) || (rd.link >= SIZE_IDX);
  // alloc ending on a zero-tag entry takes it over in place
  assign claim_now = !force_q && !hit && chain_end && (func_q == FN_ALLOC) &&
                     (rd.tag == '0);
  assign new_idx   = (ovf_q < OVF_MAX) ? (HOME_BASE + IDX_W'(ovf_q)) : CATCH_IDX;

  always_comb begin
    upd = rd;
    if (set_tag_q) begin
      upd.tag = new_tag_q;
    end else if (claim_now) begin
      upd.tag = tag_q;
    end
    if (func_q == FN_FREE) begin
      upd.count = rd.count - CNT_W'(1);
      upd.bytes = rd.bytes - CNT_W'(nbytes_q);
    end else begin
      upd.count = rd.count + CNT_W'(1);
      upd.bytes = rd.bytes + CNT_W'(nbytes_q);
    end
    if ((upd.tag == ALL_ONES) && (tag_q != ALL_ONES)) begin
      upd_status = ST_CATCHALL;
    end else if (claimed_q || claim_now) begin
      upd_status = ST_CLAIMED;
    end else begin
      upd_status = ST_UPDATED;
    end
  end

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    tag_d        = tag_q;
    nbytes_d     = nbytes_q;
    idx_d        = idx_q;
    steps_d      = steps_q;
    clr_d        = clr_q;
    ovf_d        = ovf_q;
    force_d      = force_q;
    set_tag_d    = set_tag_q;
    new_tag_d    = new_tag_q;
    claimed_d    = claimed_q;
    rdzero_d     = rdzero_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_tag_d    = rsp_tag_q;
    rsp_count_d  = rsp_count_q;
    rsp_bytes_d  = rsp_bytes_q;
    rsp_used_d   = rsp_used_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ENTRY_W'(upd);
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    term         = 1'b0;
    term_upd     = 1'b0;
    term_zero    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          tag_d     = req_i.tag;
          nbytes_d  = req_i.nbytes;
          steps_d   = '0;
          force_d   = 1'b0;
          set_tag_d = 1'b0;
          claimed_d = 1'b0;
          rdzero_d  = 1'b0;
          unique case (req_i.func)
            FN_ALLOC, FN_FREE: begin
              func_d  = func_e'(req_i.func);
              state_d = S_HASH;
            end
            FN_READ: begin
              func_d  = FN_READ;
              state_d = S_CHECK;
              if (req_i.entry_index < SIZE_IDX) begin
                ram_re    = 1'b1;
                ram_raddr = req_i.entry_index;
              end else begin
                rdzero_d = 1'b1;
              end
            end
            default: ;  // unused code, no response
          endcase
        end
      end
      S_HASH: begin
        ram_re    = 1'b1;
        ram_raddr = home_idx;
        idx_d     = home_idx;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (func_q == FN_READ) begin
          term      = 1'b1;
          term_zero = rdzero_q;
        end else if (force_q || hit || claim_now) begin
          term     = 1'b1;
          term_upd = 1'b1;
        end else if (chain_end) begin
          if (func_q == FN_FREE) begin
            term      = 1'b1;
            term_zero = 1'b1;
          end else begin
            // link a fresh overflow entry (or the catch-all) behind this one
            ram_we    = 1'b1;
            ram_waddr = idx_q;
            ram_wdata = ENTRY_W'({rd.tag, rd.count, rd.bytes, new_idx});
            ram_re    = 1'b1;
            ram_raddr = new_idx;
            idx_d     = new_idx;
            force_d   = 1'b1;
            set_tag_d = 1'b1;
            claimed_d = 1'b1;
            if (ovf_q < OVF_MAX) begin
              ovf_d     = ovf_q + OVF_W'(1);
              new_tag_d = tag_q;
            end else begin
              new_tag_d = ALL_ONES;
            end
          end
        end else begin
          ram_re = 1'b1;
          if (steps_q == LAST_IDX) begin
            // walk too long: fall back to the catch-all entry
            ram_raddr = CATCH_IDX;
            idx_d     = CATCH_IDX;
            force_d   = 1'b1;
          end else begin
            ram_raddr = rd.link;
            idx_d     = rd.link;
            steps_d   = steps_q + IDX_W'(1);
          end
        end

        if (term && out_free) begin
          state_d     = S_IDLE;
          rsp_valid_d = 1'b1;
          ram_we      = term_upd;
          ram_waddr   = idx_q;
          ram_wdata   = ENTRY_W'(upd);
          if (term_zero) begin
            rsp_status_d = (func_q == FN_READ) ? ST_READ : ST_IGNORED;
            rsp_tag_d    = '0;
            rsp_count_d  = '0;
            rsp_bytes_d  = '0;
            rsp_used_d   = 1'b0;
          end else if (term_upd) begin
            rsp_status_d = upd_status;
            rsp_tag_d    = upd.tag;
            rsp_count_d  = upd.count;
            rsp_bytes_d  = upd.bytes;
            rsp_used_d   = |(upd.tag | upd.count | upd.bytes);
          end else begin
            rsp_status_d = ST_READ;
            rsp_tag_d    = rd.tag;
            rsp_count_d  = rd.count;
            rsp_bytes_d  = rd.bytes;
            rsp_used_d   = |(rd.tag | rd.count | rd.bytes);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ovf_q       <= '0;
      rsp_valid_q <= 1'b0;
      text_base_q <= '0;
      shift_q     <= SHIFT_RESET;
      func_q      <= FN_ALLOC;
      steps_q     <= '0;
      force_q     <= 1'b0;
      set_tag_q   <= 1'b0;
      claimed_q   <= 1'b0;
      rdzero_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ovf_q       <= ovf_d;
      rsp_valid_q <= rsp_valid_d;
      func_q      <= func_d;
      steps_q     <= steps_d;
      force_q     <= force_d;
      set_tag_q   <= set_tag_d;
      claimed_q   <= claimed_d;
      rdzero_q    <= rdzero_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TEXT_BASE:     text_base_q <= cfg_wdata_i;
          CFG_GRANULE_SHIFT: shift_q     <= cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q        <= tag_d;
    nbytes_q     <= nbytes_d;
    idx_q        <= idx_d;
    new_tag_q    <= new_tag_d;
    rsp_status_q <= rsp_status_d;
    rsp_tag_q    <= rsp_tag_d;
    rsp_count_q  <= rsp_count_d;
    rsp_bytes_q  <= rsp_bytes_d;
    rsp_used_q   <= rsp_used_d;
  end

`ifndef SYNTHESIS
  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q <= OVF_MAX)
    else $error("overflow count past the overflow area");

  a_rsp_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_CHECK))
    else $error("response raised outside the check step");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (ram_raddr < SIZE_IDX) && (state_q != S_CLEAR))
    else $error("table read out of range or during clearing");

  a_link_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) && ram_we && !term |=> (state_q == S_CHECK) && force_q)
    else $error("overflow link written without a follow-up claim");
`endif

endmodule
